// File: src/tcc_pkg.sv
// Package with the shared types, codes and limits of the text console cursor control.
`default_nettype none
package tcc_pkg;

   localparam int MAX_COLUMNS    = 128;
   localparam int MAX_ROWS_LIMIT = 64;

   // Effective screen limits are also bounded by the 7-bit column and 6-bit row fields.
   localparam int COL_LIMIT = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
   localparam int ROW_LIMIT = (MAX_ROWS_LIMIT < 64) ? MAX_ROWS_LIMIT : 64;

   localparam int LIST_DEPTH = 4;

   localparam logic [7:0]  COLUMN_COUNT_RESET = 8'd102;
   localparam logic [6:0]  ROW_COUNT_RESET    = 7'd40;
   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd50;

   localparam logic [7:0] TAB_STEP = 8'd8;
   localparam logic [7:0] TAB_MASK = ~8'd7;

   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_HT = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef enum logic [2:0] {
      ACT_CHAR  = 3'd0,
      ACT_TICK  = 3'd1,
      ACT_MOVE  = 3'd2,
      ACT_SHOW  = 3'd3,
      ACT_CLEAR = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CMD_CURSOR       = 3'd0,
      CMD_GLYPH        = 3'd1,
      CMD_CLEAR_CELL   = 3'd2,
      CMD_SCROLL       = 3'd3,
      CMD_CLEAR_SCREEN = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      CSR_COLUMN_COUNT = 2'd0,
      CSR_ROW_COUNT    = 2'd1,
      CSR_BLINK_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      command_type command;
      logic [6:0]  cell_col;
      logic [5:0]  cell_row;
      logic [7:0]  glyph_code;
      logic        cursor_lit;
      logic        last;
   } cmd_type;

   function automatic cmd_type make_cmd(command_type cmd, logic [6:0] col, logic [5:0] row,
                                        logic [7:0] glyph, logic lit);
      cmd_type c;
      c.command    = cmd;
      c.cell_col   = col;
      c.cell_row   = row;
      c.glyph_code = glyph;
      c.cursor_lit = lit;
      c.last       = 1'b0;
      return c;
   endfunction

endpackage
`default_nettype wire

// File: src/tcc_channels.sv
// Valid/ready channel interfaces for console input items and draw command items.
`default_nettype none
interface tcc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] char_code;
   logic [6:0] target_col;
   logic [5:0] target_row;
   logic       show_cursor;

   modport source (output valid, output action, output char_code, output target_col,
                   output target_row, output show_cursor, input ready);
   modport sink   (input valid, input action, input char_code, input target_col,
                   input target_row, input show_cursor, output ready);
endinterface

interface tcc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [6:0] cell_col;
   logic [5:0] cell_row;
   logic [7:0] glyph_code;
   logic       cursor_lit;
   logic       last;

   modport source (output valid, output command, output cell_col, output cell_row,
                   output glyph_code, output cursor_lit, output last, input ready);
   modport sink   (input valid, input command, input cell_col, input cell_row,
                   input glyph_code, input cursor_lit, input last, output ready);
endinterface
`default_nettype wire

// File: src/text_console_cursor_control.sv
// Top level of the text console cursor control: cursor state and draw command list.
//
// Each input item is decoded in the cycle it is accepted: the cursor state is updated at
// once and the item's zero to four draw commands are loaded into a four-entry result list,
// which hands out one command per cycle while the sink is ready. An item is accepted when the
// list is empty or its final command leaves in the same cycle. A character yields two to
// four commands, a move two or none, a tick or visibility change one or none, a clear two,
// and other action codes none. Configuration writes take effect on the next item.
`default_nettype none
module text_console_cursor_control (
   input  wire logic        clock,
   input  wire logic        reset,
   tcc_req_if.sink          req_ch,
   tcc_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import tcc_pkg::*;

   logic [7:0]  col_count_ff;
   logic [6:0]  row_count_ff;
   logic [15:0] blink_period_ff;

   logic [6:0]  cursor_col_ff, cursor_col_in;
   logic [5:0]  cursor_row_ff, cursor_row_in;
   logic        shown_ff, shown_in;
   logic [15:0] ticks_ff, ticks_in;

   cmd_type     list_ff [LIST_DEPTH];
   cmd_type     list_in [LIST_DEPTH];
   logic [2:0]  left_ff, left_in;

   logic        req_take, rsp_take;
   logic [7:0]  eff_cols;
   logic [6:0]  eff_rows;
   action_type  act;

   assign act      = action_type'(req_ch.action);
   assign rsp_take = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   always_comb begin
      if (col_count_ff == 8'd0) begin
         eff_cols = 8'd1;
      end else if (col_count_ff > 8'(COL_LIMIT)) begin
         eff_cols = 8'(COL_LIMIT);
      end else begin
         eff_cols = col_count_ff;
      end
      if (row_count_ff == 7'd0) begin
         eff_rows = 7'd1;
      end else if (row_count_ff > 7'(ROW_LIMIT)) begin
         eff_rows = 7'(ROW_LIMIT);
      end else begin
         eff_rows = row_count_ff;
      end
   end

   // Decode of one item into new cursor state and its command list.
   always_comb begin
      logic [7:0]  col;
      logic [6:0]  row;
      logic [15:0] period;
      logic [15:0] tick_next;
      logic [2:0]  n;
      logic [1:0]  last_idx;

      col       = {1'b0, cursor_col_ff};
      row       = {1'b0, cursor_row_ff};
      period    = (blink_period_ff == 16'd0) ? 16'd1 : blink_period_ff;
      tick_next = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
      n         = 3'd0;
      last_idx  = 2'd0;

      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      shown_in      = shown_ff;
      ticks_in      = ticks_ff;
      for (int i = 0; i < LIST_DEPTH; i++) begin
         list_in[i] = make_cmd(CMD_CURSOR, 7'd0, 6'd0, 8'd0, 1'b0);
      end

      case (act)
         ACT_CHAR: begin
            list_in[0] = make_cmd(CMD_CURSOR, cursor_col_ff, cursor_row_ff, 8'd0, 1'b0);
            n = 3'd1;
            if (req_ch.char_code == CHAR_LF) begin
               col = 8'd0;
               row = row + 7'd1;
            end else if (req_ch.char_code == CHAR_CR) begin
               col = 8'd0;
            end else if (req_ch.char_code == CHAR_HT) begin
               col = (col + TAB_STEP) & TAB_MASK;
            end else if (req_ch.char_code == CHAR_BS) begin
               if (col != 8'd0) begin
                  col = col - 8'd1;
                  list_in[1] = make_cmd(CMD_CLEAR_CELL, col[6:0], row[5:0], 8'd0, 1'b0);
                  n = 3'd2;
               end
            end else begin
               list_in[1] = make_cmd(CMD_GLYPH, col[6:0], row[5:0], req_ch.char_code, 1'b0);
               n = 3'd2;
               col = col + 8'd1;
            end
            if (col >= eff_cols) begin
               col = 8'd0;
               row = row + 7'd1;
            end
            // A cursor past a shrunken screen still scrolls only once.
            if (row >= eff_rows) begin
               list_in[n[1:0]] = make_cmd(CMD_SCROLL, 7'd0, 6'd0, 8'd0, 1'b0);
               n = n + 3'd1;
               row = row - 7'd1;
            end
            cursor_col_in = col[6:0];
            cursor_row_in = row[5:0];
            list_in[n[1:0]] = make_cmd(CMD_CURSOR, col[6:0], row[5:0], 8'd0, shown_ff);
            n = n + 3'd1;
         end
         ACT_TICK: begin
            ticks_in = tick_next;
            if (tick_next >= period) begin
               shown_in   = ~shown_ff;
               ticks_in   = 16'd0;
               list_in[0] = make_cmd(CMD_CURSOR, cursor_col_ff, cursor_row_ff, 8'd0,
                                     ~shown_ff);
               n = 3'd1;
            end
         end
         ACT_MOVE: begin
            if (({1'b0, req_ch.target_col} < eff_cols) &&
                ({1'b0, req_ch.target_row} < eff_rows)) begin
               list_in[0] = make_cmd(CMD_CURSOR, cursor_col_ff, cursor_row_ff, 8'd0, 1'b0);
               list_in[1] = make_cmd(CMD_CURSOR, req_ch.target_col, req_ch.target_row, 8'd0,
                                     shown_ff);
               cursor_col_in = req_ch.target_col;
               cursor_row_in = req_ch.target_row;
               n = 3'd2;
            end
         end
         ACT_SHOW: begin
            if (req_ch.show_cursor != shown_ff) begin
               shown_in   = req_ch.show_cursor;
               list_in[0] = make_cmd(CMD_CURSOR, cursor_col_ff, cursor_row_ff, 8'd0,
                                     req_ch.show_cursor);
               n = 3'd1;
            end
         end
         ACT_CLEAR: begin
            list_in[0]    = make_cmd(CMD_CLEAR_SCREEN, 7'd0, 6'd0, 8'd0, 1'b0);
            list_in[1]    = make_cmd(CMD_CURSOR, 7'd0, 6'd0, 8'd0, 1'b1);
            cursor_col_in = 7'd0;
            cursor_row_in = 6'd0;
            shown_in      = 1'b1;
            ticks_in      = 16'd0;
            n = 3'd2;
         end
         default: begin
            n = 3'd0;
         end
      endcase

      if (n != 3'd0) begin
         last_idx = 2'(n - 3'd1);
         list_in[last_idx].last = 1'b1;
      end
      left_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff    <= COLUMN_COUNT_RESET;
         row_count_ff    <= ROW_COUNT_RESET;
         blink_period_ff <= BLINK_PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMN_COUNT: col_count_ff    <= csr_wdata[7:0];
            CSR_ROW_COUNT:    row_count_ff    <= csr_wdata[6:0];
            CSR_BLINK_PERIOD: blink_period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 7'd0;
         cursor_row_ff <= 6'd0;
         shown_ff      <= 1'b1;
         ticks_ff      <= 16'd0;
         left_ff       <= 3'd0;
      end else if (req_take) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         shown_ff      <= shown_in;
         ticks_ff      <= ticks_in;
         left_ff       <= left_in;
      end else if (rsp_take) begin
         left_ff <= left_ff - 3'd1;
      end
   end

   // The list shifts toward entry 0 as commands leave.
   always_ff @(posedge clock) begin
      if (req_take) begin
         list_ff <= list_in;
      end else if (rsp_take) begin
         for (int i = 0; i < LIST_DEPTH - 1; i++) begin
            list_ff[i] <= list_ff[i + 1];
         end
      end
   end

   assign rsp_ch.valid      = (left_ff != 3'd0);
   assign rsp_ch.command    = list_ff[0].command;
   assign rsp_ch.cell_col   = list_ff[0].cell_col;
   assign rsp_ch.cell_row   = list_ff[0].cell_row;
   assign rsp_ch.glyph_code = list_ff[0].glyph_code;
   assign rsp_ch.cursor_lit = list_ff[0].cursor_lit;
   assign rsp_ch.last       = list_ff[0].last;

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'(LIST_DEPTH))
      else $error("command list count above its depth");

   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.last == (left_ff == 3'd1)))
      else $error("last flag disagrees with remaining command count");

   a_char_yields_two: assert property (@(posedge clock) disable iff (reset)
      req_take && (act == ACT_CHAR) |=> (left_ff >= 3'd2))
      else $error("character item produced fewer than two commands");

   a_clear_homes: assert property (@(posedge clock) disable iff (reset)
      req_take && (act == ACT_CLEAR) |=>
         (cursor_col_ff == 7'd0) && (cursor_row_ff == 6'd0) && shown_ff && (ticks_ff == 16'd0))
      else $error("clear did not home and show the cursor");

endmodule
`default_nettype wire

// File: tb/sv/text_console_cursor_control_checker.sv
// Checker that predicts the draw commands of the console cursor control and compares them.
`timescale 1ns / 1ps
module text_console_cursor_control_checker
   import tcc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tcc_req_if          req_ch,
   tcc_rsp_if          rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          outstanding,
   output int          commands_seen
);

   logic [7:0]  columns_reg;
   logic [6:0]  rows_reg;
   logic [15:0] blink_reg;

   logic [6:0]  cursor_col;
   logic [5:0]  cursor_row;
   logic        cursor_on;
   logic [15:0] blink_ticks;

   cmd_type     expected_cmds[$];
   cmd_type     item_cmds[$];
   int          errors = 0;
   int          seen = 0;

   function automatic void add_cmd(command_type kind, int col, int row, logic [7:0] glyph,
                                   logic lit);
      cmd_type c;
      c.command    = kind;
      c.cell_col   = 7'(col);
      c.cell_row   = 6'(row);
      c.glyph_code = glyph;
      c.cursor_lit = lit;
      c.last       = 1'b0;
      item_cmds.push_back(c);
   endfunction

   // Updates the cursor state for one item and queues the draw commands it should produce.
   function automatic void draw_for_item(logic [2:0] act, logic [7:0] code, logic [6:0] tcol,
                                         logic [5:0] trow, logic vis);
      int col;
      int row;
      int cols;
      int rows;
      int period;
      cols = (columns_reg == 8'd0) ? 1 : int'(columns_reg);
      if (cols > COL_LIMIT) cols = COL_LIMIT;
      rows = (rows_reg == 7'd0) ? 1 : int'(rows_reg);
      if (rows > ROW_LIMIT) rows = ROW_LIMIT;
      item_cmds.delete();
      case (act)
         ACT_CHAR: begin
            col = cursor_col;
            row = cursor_row;
            add_cmd(CMD_CURSOR, col, row, 8'd0, 1'b0);
            if (code == CHAR_LF) begin
               col = 0;
               row++;
            end else if (code == CHAR_CR) begin
               col = 0;
            end else if (code == CHAR_HT) begin
               col = (col / 8 + 1) * 8;
            end else if (code == CHAR_BS) begin
               if (col > 0) begin
                  col--;
                  add_cmd(CMD_CLEAR_CELL, col, row, 8'd0, 1'b0);
               end
            end else begin
               add_cmd(CMD_GLYPH, col, row, code, 1'b0);
               col++;
            end
            if (col >= cols) begin
               col = 0;
               row++;
            end
            // A cursor left below a shrunken screen still scrolls only once.
            if (row >= rows) begin
               add_cmd(CMD_SCROLL, 0, 0, 8'd0, 1'b0);
               row--;
            end
            cursor_col = 7'(col);
            cursor_row = 6'(row);
            add_cmd(CMD_CURSOR, cursor_col, cursor_row, 8'd0, cursor_on);
         end
         ACT_TICK: begin
            period = (blink_reg == 16'd0) ? 1 : int'(blink_reg);
            if (blink_ticks != 16'hFFFF) blink_ticks++;
            if (int'(blink_ticks) >= period) begin
               cursor_on   = !cursor_on;
               blink_ticks = '0;
               add_cmd(CMD_CURSOR, cursor_col, cursor_row, 8'd0, cursor_on);
            end
         end
         ACT_MOVE: begin
            if (int'(tcol) < cols && int'(trow) < rows) begin
               add_cmd(CMD_CURSOR, cursor_col, cursor_row, 8'd0, 1'b0);
               cursor_col = tcol;
               cursor_row = trow;
               add_cmd(CMD_CURSOR, cursor_col, cursor_row, 8'd0, cursor_on);
            end
         end
         ACT_SHOW: begin
            if (vis != cursor_on) begin
               cursor_on = vis;
               add_cmd(CMD_CURSOR, cursor_col, cursor_row, 8'd0, cursor_on);
            end
         end
         ACT_CLEAR: begin
            add_cmd(CMD_CLEAR_SCREEN, 0, 0, 8'd0, 1'b0);
            cursor_col  = '0;
            cursor_row  = '0;
            cursor_on   = 1'b1;
            blink_ticks = '0;
            add_cmd(CMD_CURSOR, 0, 0, 8'd0, 1'b1);
         end
         default: ;
      endcase
      if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
      foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      cmd_type want;
      if (reset) begin
         columns_reg = COLUMN_COUNT_RESET;
         rows_reg    = ROW_COUNT_RESET;
         blink_reg   = BLINK_PERIOD_RESET;
         cursor_col  = '0;
         cursor_row  = '0;
         cursor_on   = 1'b1;
         blink_ticks = '0;
         expected_cmds.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            draw_for_item(req_ch.action, req_ch.char_code, req_ch.target_col,
                          req_ch.target_row, req_ch.show_cursor);
         if (csr_we) begin
            case (csr_index)
               CSR_COLUMN_COUNT: columns_reg = csr_wdata[7:0];
               CSR_ROW_COUNT:    rows_reg    = csr_wdata[6:0];
               CSR_BLINK_PERIOD: blink_reg   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen++;
            if (expected_cmds.size() == 0) begin
               errors++;
               $error("draw command %0d at column %0d, row %0d with nothing expected",
                      rsp_ch.command, rsp_ch.cell_col, rsp_ch.cell_row);
            end else begin
               want = expected_cmds.pop_front();
               check_field("command", want.command, rsp_ch.command);
               check_field("cell_col", want.cell_col, rsp_ch.cell_col);
               check_field("cell_row", want.cell_row, rsp_ch.cell_row);
               check_field("glyph_code", want.glyph_code, rsp_ch.glyph_code);
               check_field("cursor_lit", want.cursor_lit, rsp_ch.cursor_lit);
               check_field("last", want.last, rsp_ch.last);
            end
         end
      end
      fail_count    <= errors;
      outstanding   <= expected_cmds.size();
      commands_seen <= seen;
   end

endmodule

// File: tb/sv/text_console_cursor_control_test.sv
// Top of the console cursor control testbench: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps
module text_console_cursor_control_test;
   import tcc_pkg::*;

   localparam int STALL_LIMIT     = 5000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 40;

   // Action codes that the block has no use for.
   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_MID = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          send_idle_pct;
   int          take_idle_pct;
   int          fail_count;
   int          outstanding;
   int          commands_seen;
   int          items_sent = 0;
   int          chars_sent = 0;
   int          settings_used = 0;
   int          eff_cols;
   int          eff_rows;

   int          phase_cols[RANDOM_PHASES]  = '{16, 1, 0, 128, 255, 40};
   int          phase_rows[RANDOM_PHASES]  = '{4, 2, 0, 64, 127, 8};
   int          phase_blink[RANDOM_PHASES] = '{3, 1, 0, 65535, 5, 4};

   tcc_req_if req_ch();
   tcc_rsp_if rsp_ch();

   text_console_cursor_control dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   text_console_cursor_control_checker draw_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .commands_seen (commands_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   task automatic send_item(logic [2:0] act, logic [7:0] code, logic [6:0] tcol,
                            logic [5:0] trow, logic vis);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.char_code   <= code;
      req_ch.target_col  <= tcol;
      req_ch.target_row  <= trow;
      req_ch.show_cursor <= vis;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (act == ACT_CHAR) chars_sent++;
   endtask

   task automatic send_random_item();
      int unsigned roll;
      logic [2:0]  act;
      logic [7:0]  code;
      logic [6:0]  tcol;
      logic [5:0]  trow;
      roll = $urandom_range(99);
      code = 8'($urandom_range(255));
      tcol = 7'($urandom_range(127));
      trow = 6'($urandom_range(63));
      if (roll < 55) begin
         act = ACT_CHAR;
         case ($urandom_range(9))
            0: code = CHAR_LF;
            1: code = CHAR_CR;
            2: code = CHAR_HT;
            3: code = CHAR_BS;
            4, 5, 6: code = 8'($urandom_range(126, 32));
            default: ;
         endcase
      end else if (roll < 70) begin
         act = ACT_TICK;
      end else if (roll < 83) begin
         act = ACT_MOVE;
         // Most moves land on the screen; the rest keep the full field range.
         if ($urandom_range(3) != 0) begin
            tcol = 7'($urandom_range(eff_cols - 1));
            trow = 6'($urandom_range(eff_rows - 1));
         end
      end else if (roll < 91) begin
         act = ACT_SHOW;
      end else if (roll < 95) begin
         act = ACT_CLEAR;
      end else begin
         act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      end
      send_item(act, code, tcol, trow, 1'($urandom_range(1)));
   endtask

   // Drops valid, waits for every pending command and lets a trailing item finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic load_settings(int cols, int rows, int blink);
      write_reg(CSR_COLUMN_COUNT, 16'(cols));
      write_reg(CSR_ROW_COUNT, 16'(rows));
      write_reg(CSR_BLINK_PERIOD, 16'(blink));
      @(posedge clock);
      csr_we   <= 1'b0;
      eff_cols = (cols == 0) ? 1 : ((cols > COL_LIMIT) ? COL_LIMIT : cols);
      eff_rows = (rows == 0) ? 1 : ((rows > ROW_LIMIT) ? ROW_LIMIT : rows);
      settings_used++;
   endtask

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall = 0;
         else
            stall++;
      end
      $display("Watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("** text_console_cursor_control: FAILED **");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_COLUMN_COUNT;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_CHAR;
      req_ch.char_code   <= '0;
      req_ch.target_col  <= '0;
      req_ch.target_row  <= '0;
      req_ch.show_cursor <= 1'b0;
      send_idle_pct = 25;
      take_idle_pct = 69;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A tiny screen so that wrap and scroll come quickly.
      load_settings(10, 3, 2);
      send_item(ACT_CLEAR, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, 8'h41, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_BS, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_BS, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_HT, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, 8'hFF, 7'd127, 6'd63, 1'b1);
      send_item(ACT_CHAR, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_LF, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_LF, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, CHAR_CR, 7'd0, 6'd0, 1'b0);
      send_item(ACT_CHAR, 8'h1B, 7'd0, 6'd0, 1'b0);
      send_item(ACT_MOVE, 8'h00, 7'd9, 6'd2, 1'b0);
      send_item(ACT_MOVE, 8'h00, 7'd127, 6'd63, 1'b1);
      send_item(ACT_MOVE, 8'h00, 7'd10, 6'd0, 1'b0);
      send_item(ACT_MOVE, 8'h00, 7'd0, 6'd3, 1'b0);
      send_item(ACT_CHAR, CHAR_HT, 7'd0, 6'd0, 1'b0);
      send_item(ACT_SHOW, 8'h00, 7'd0, 6'd0, 1'b1);
      send_item(ACT_SHOW, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_TICK, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_TICK, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_SPARE_LO, 8'hFF, 7'd127, 6'd63, 1'b1);
      send_item(ACT_SPARE_MID, 8'h00, 7'd0, 6'd0, 1'b0);
      send_item(ACT_SPARE_HI, 8'h0A, 7'd5, 6'd1, 1'b1);
      send_item(ACT_MOVE, 8'h00, 7'd9, 6'd2, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         load_settings(phase_cols[p], phase_rows[p], phase_blink[p]);
         case (p / 2)
            0: begin
               send_idle_pct = 25;
               take_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               take_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_item();
         // Park the cursor in the far corner so that, where the next screen is smaller, it starts past its edge.
         send_item(ACT_MOVE, 8'h00, 7'(eff_cols - 1), 6'(eff_rows - 1), 1'b0);
      end

      settle();
      $display("Ran %0d console items (%0d characters) and checked %0d draw commands,",
               items_sent, chars_sent, commands_seen);
      $display("over %0d register settings and three pacing patterns.", settings_used);
      if (fail_count == 0 && outstanding == 0)
         $display("** text_console_cursor_control: PASSED **");
      else
         $display("** text_console_cursor_control: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
src/tcc_pkg.sv
src/tcc_channels.sv
src/text_console_cursor_control.sv
tb/sv/text_console_cursor_control_checker.sv
tb/sv/text_console_cursor_control_test.sv
